@@ hw/rtl/shutter_motor_position_controller_top_macros.svh @@
// Assertion macros shared by the shutter controller checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef SHUTTER_MOTOR_POSITION_CONTROLLER_TOP_MACROS_SVH
`define SHUTTER_MOTOR_POSITION_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SMPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/smpc_pkg.sv @@
// Types and constants of the shutter motor position controller.
// No dependencies; imported by the interfaces, the testbench and all modules but smpc_checker.
package smpc_pkg;

	localparam int unsigned CFG_BITS      = 10;
	localparam int unsigned APB_ADDR_BITS = 3;
	localparam int unsigned APB_DATA_BITS = 32;

	localparam logic [CFG_BITS-1:0] FULL_TRAVEL_RESET = 10'd1000;
	localparam logic [CFG_BITS-1:0] VENT_TARGET_RESET = 10'd500;

	typedef enum logic [2:0] {
		OP_TICK    = 3'd0,
		OP_UP      = 3'd1,
		OP_DOWN    = 3'd2,
		OP_VENT    = 3'd3,
		OP_RESTORE = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		DIR_IDLE = 3'b001,
		DIR_UP   = 3'b010,
		DIR_DOWN = 3'b100
	} dir_t;

	typedef enum logic [0:0] {
		REG_FULL_TRAVEL = 1'b0,
		REG_VENT_TARGET = 1'b1
	} reg_idx_t;

	localparam int unsigned LOCK_UP_BIT   = 0;
	localparam int unsigned LOCK_DOWN_BIT = 1;

	typedef struct packed {
		logic [CFG_BITS-1:0] full_travel;
		logic [CFG_BITS-1:0] vent_target;
	} cfg_t;

endpackage

@@ hw/rtl/smpc_item_if.sv @@
// Input channel of the shutter controller: one event per transaction.
// Depends on smpc_pkg.
interface smpc_item_if import smpc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [2:0]          opcode;
	logic                button_released;
	logic [CFG_BITS-1:0] restore_value;

	modport source (output valid, opcode, button_released, restore_value, input ready);
	modport sink (input valid, opcode, button_released, restore_value, output ready);
endinterface

@@ hw/rtl/smpc_result_if.sv @@
// Result channel of the shutter controller: motor drive and status per transaction.
// Depends on smpc_pkg.
interface smpc_result_if import smpc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                drive_open;
	logic                drive_close;
	logic [CFG_BITS-1:0] position_now;
	logic                vent_mode;
	logic                save_strobe;

	modport source (output valid, drive_open, drive_close, position_now, vent_mode, save_strobe,
		input ready);
	modport sink (input valid, drive_open, drive_close, position_now, vent_mode, save_strobe,
		output ready);
endinterface

@@ hw/rtl/shutter_motor_position_controller_top.sv @@
// Roller-shutter motor position controller.
// Channels: item (sink) takes one event per transaction: travel tick, up or down
// button sample, ventilation request or position restore. result (source) gives
// exactly one transaction per event: motor drive, position, mode and save strobe.
// Config: APB port with full_travel at 0x0 and vent_target at 0x4; pready is
// always high and a write lands at the access cycle.
// Result timing: registered, so the result appears in the cycle after the event is taken.
// Throughput: one event per cycle unless a held result stalls the input; the state
// update and the result register are written together, and the result register is
// refilled in the same cycle it is emptied.
// Reset: position 0, motor off, basic mode, both buttons unlocked,
// full_travel 1000, vent_target 500; no result pending.
// Stall: while a result waits, item.ready follows result.ready, so a held
// result holds off the next event without losing it.
// Depends on smpc_pkg, smpc_item_if, smpc_result_if, smpc_cfg_regs and smpc_core.
module shutter_motor_position_controller_top import smpc_pkg::*; #(
	parameter int unsigned POSITION_BITS = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	smpc_item_if.sink                item,
	smpc_result_if.source            result,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	cfg_t cfg;

	smpc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	smpc_core #(
		.POSITION_BITS (POSITION_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item),
		.result (result)
	);

endmodule

@@ hw/rtl/smpc_cfg_regs.sv @@
// APB register block holding full travel and ventilation target.
// Depends on smpc_pkg.
module smpc_cfg_regs import smpc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [APB_ADDR_BITS-1:0] paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready,
	output cfg_t                     cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_travel <= FULL_TRAVEL_RESET;
			cfg_q.vent_target <= VENT_TARGET_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_FULL_TRAVEL: cfg_q.full_travel <= pwdata[CFG_BITS-1:0];
				REG_VENT_TARGET: cfg_q.vent_target <= pwdata[CFG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_FULL_TRAVEL: prdata = APB_DATA_BITS'(cfg_q.full_travel);
			REG_VENT_TARGET: prdata = APB_DATA_BITS'(cfg_q.vent_target);
			default: prdata = '0;
		endcase
	end

endmodule

@@ hw/rtl/smpc_core.sv @@
// Shutter state (position, direction, mode, press locks) and result register.
// Depends on smpc_pkg, smpc_item_if and smpc_result_if.
module smpc_core import smpc_pkg::*; #(
	parameter int unsigned POSITION_BITS = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	smpc_item_if.sink     item,
	smpc_result_if.source result
);

	logic [POSITION_BITS-1:0] pos_q, pos_d;
	dir_t                     dir_q, dir_d, dir_mid;
	logic                     mode_q, mode_d;
	logic [1:0]               lock_q, lock_d;
	logic                     strobe_d;

	logic [POSITION_BITS-1:0] ft_w, vt_w;
	logic [CFG_BITS-1:0]      restore_sat;
	op_t                      op;
	logic                     is_up, locked, can_start;
	logic                     lock_idx;
	dir_t                     toward, opposite;
	logic                     accept;

	logic                     res_valid_q;
	logic                     res_up_q, res_down_q, res_mode_q, res_strobe_q;
	logic [CFG_BITS-1:0]      res_pos_q;

	assign ft_w        = POSITION_BITS'(cfg.full_travel);
	assign vt_w        = POSITION_BITS'(cfg.vent_target);
	assign restore_sat = (item.restore_value > cfg.full_travel) ? cfg.full_travel
		: item.restore_value;
	assign op          = op_t'(item.opcode);

	assign is_up     = (op == OP_UP);
	assign lock_idx  = is_up ? 1'(LOCK_UP_BIT) : 1'(LOCK_DOWN_BIT);
	assign locked    = lock_q[lock_idx];
	assign toward    = is_up ? DIR_UP : DIR_DOWN;
	assign opposite  = is_up ? DIR_DOWN : DIR_UP;
	assign can_start = is_up ? (pos_q != '0) : (pos_q < ft_w);

	assign item.ready = !res_valid_q || result.ready;
	assign accept     = item.valid && item.ready;

	always_comb begin
		pos_d    = pos_q;
		dir_d    = dir_q;
		mode_d   = mode_q;
		lock_d   = lock_q;
		strobe_d = 1'b0;
		dir_mid  = dir_q;
		unique case (op) inside
			OP_TICK: begin
				if (dir_q != DIR_IDLE) begin
					if (dir_q == DIR_DOWN) begin
						pos_d = (pos_q >= ft_w) ? ft_w : pos_q + POSITION_BITS'(1);
					end else if (pos_q != '0) begin
						pos_d = pos_q - POSITION_BITS'(1);
					end
					// Stop at either end, or at the target while ventilating.
					if (pos_d >= ft_w || pos_d == '0 || (mode_q && pos_d == vt_w)) begin
						dir_d    = DIR_IDLE;
						mode_d   = 1'b0;
						strobe_d = 1'b1;
					end
				end
			end
			OP_UP, OP_DOWN: begin
				if (!locked && !item.button_released) begin
					lock_d[lock_idx] = 1'b1;
					// A press against the running direction stops, then starts the pressed way if it can.
					if (dir_q == opposite) begin
						dir_d    = DIR_IDLE;
						mode_d   = 1'b0;
						strobe_d = 1'b1;
						dir_mid  = DIR_IDLE;
					end
					if (dir_mid == DIR_IDLE && can_start) begin
						dir_d = toward;
					end
				end else if (locked && item.button_released) begin
					dir_d            = DIR_IDLE;
					mode_d           = 1'b0;
					strobe_d         = 1'b1;
					lock_d[lock_idx] = 1'b0;
				end
			end
			OP_VENT: begin
				if (dir_q == DIR_IDLE) begin
					mode_d = 1'b1;
					if (pos_q < vt_w) begin
						if (pos_q < ft_w) begin
							dir_d = DIR_DOWN;
						end
					end else if (pos_q > vt_w) begin
						dir_d = DIR_UP;
					end
				end
			end
			OP_RESTORE: begin
				pos_d = POSITION_BITS'(restore_sat);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			dir_q       <= DIR_IDLE;
			mode_q      <= 1'b0;
			lock_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				pos_q       <= pos_d;
				dir_q       <= dir_d;
				mode_q      <= mode_d;
				lock_q      <= lock_d;
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_up_q     <= (dir_d == DIR_UP);
			res_down_q   <= (dir_d == DIR_DOWN);
			res_pos_q    <= pos_d[CFG_BITS-1:0];
			res_mode_q   <= mode_d;
			res_strobe_q <= strobe_d;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.drive_open   = res_up_q;
	assign result.drive_close  = res_down_q;
	assign result.position_now = res_pos_q;
	assign result.vent_mode    = res_mode_q;
	assign result.save_strobe  = res_strobe_q;

endmodule

@@ hw/rtl/smpc_checker.sv @@
// Port-level assertions for the shutter controller, bound to the top level.
// Depends on shutter_motor_position_controller_top_macros.svh.
`include "shutter_motor_position_controller_top_macros.svh"

module smpc_checker (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input logic result_valid,
	input logic result_ready,
	input logic drive_open,
	input logic drive_close
);

	`SMPC_ASSERT_NXT(a_result_held, clk, arst_n, result_valid && !result_ready, result_valid, "result dropped while stalled")
	`SMPC_ASSERT_NXT(a_accept_gives_result, clk, arst_n, item_valid && item_ready, result_valid, "accepted transaction gave no result")
	`SMPC_ASSERT_IMP(a_ready_when_empty, clk, arst_n, !result_valid, item_ready, "input not ready with empty result register")
	`SMPC_ASSERT_IMP(a_motor_exclusive, clk, arst_n, result_valid, !(drive_open && drive_close), "motor driven both ways")

endmodule

bind shutter_motor_position_controller_top smpc_checker u_smpc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.drive_open   (result.drive_open),
	.drive_close  (result.drive_close)
);

@@ tb/shutter_motor_position_controller_top_tb.sv @@
// Testbench of the shutter motor position controller: directed and random events.
// Its own shutter model predicts each result, which is checked field by field.
// Depends on smpc_pkg, smpc_item_if, smpc_result_if and the controller top level.
`timescale 1ns / 1ps

module shutter_motor_position_controller_top_tb;
	import smpc_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 400;

	typedef struct packed {
		logic [2:0] op;
		logic       rel;
		logic [9:0] rv;
	} shutter_item_t;

	typedef struct packed {
		logic       drive_open;
		logic       drive_close;
		logic [9:0] position_now;
		logic       vent_mode;
		logic       save_strobe;
	} shutter_status_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic pready;

	smpc_item_if item_bus ();
	smpc_result_if result_bus ();

	shutter_motor_position_controller_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_bus),
		.result(result_bus),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Shutter model: configuration and state.
	logic [9:0] m_travel;
	logic [9:0] m_vent_pos;
	logic [9:0] m_pos;
	dir_t       m_dir;
	logic       m_vent;
	logic [1:0] m_lock;
	logic       m_strobe;

	shutter_item_t   pending_items[$];
	shutter_status_t expected_status[$];
	shutter_item_t   next_item;
	shutter_status_t want;

	int unsigned queued_count;
	int unsigned accepted_count;
	int unsigned mismatches;
	int unsigned idle_cycles;
	int unsigned send_wait;
	int unsigned recv_wait;
	bit send_steady;
	bit recv_steady;
	logic in_fire;
	logic out_fire;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic void halt_motor();
		m_dir = DIR_IDLE;
		m_vent = 1'b0;
		m_strobe = 1'b1;
	endfunction

	function automatic void try_start(dir_t toward);
		if (m_dir == DIR_IDLE) begin
			if (toward == DIR_UP && m_pos != 10'd0)
				m_dir = DIR_UP;
			else if (toward == DIR_DOWN && m_pos < m_travel)
				m_dir = DIR_DOWN;
		end
	endfunction

	function automatic shutter_status_t advance_shutter(logic [2:0] op, logic rel, logic [9:0] rv);
		shutter_status_t s;
		int unsigned lock_bit;
		dir_t toward;
		dir_t against;
		m_strobe = 1'b0;
		case (op)
			OP_TICK: begin
				if (m_dir != DIR_IDLE) begin
					if (m_dir == DIR_DOWN)
						m_pos = (m_pos >= m_travel) ? m_travel : m_pos + 10'd1;
					else if (m_pos != 10'd0)
						m_pos = m_pos - 10'd1;
					if (m_pos >= m_travel || m_pos == 10'd0 || (m_vent && m_pos == m_vent_pos))
						halt_motor();
				end
			end
			OP_UP, OP_DOWN: begin
				if (op == OP_UP) begin
					lock_bit = LOCK_UP_BIT;
					toward = DIR_UP;
					against = DIR_DOWN;
				end else begin
					lock_bit = LOCK_DOWN_BIT;
					toward = DIR_DOWN;
					against = DIR_UP;
				end
				if (!m_lock[lock_bit] && !rel) begin
					m_lock[lock_bit] = 1'b1;
					if (m_dir == against)
						halt_motor();
					try_start(toward);
				end else if (m_lock[lock_bit] && rel) begin
					halt_motor();
					m_lock[lock_bit] = 1'b0;
				end
			end
			OP_VENT: begin
				if (m_dir == DIR_IDLE) begin
					m_vent = 1'b1;
					if (m_pos < m_vent_pos)
						try_start(DIR_DOWN);
					else if (m_pos > m_vent_pos)
						try_start(DIR_UP);
				end
			end
			OP_RESTORE: m_pos = (rv > m_travel) ? m_travel : rv;
			default: ;
		endcase
		s.drive_open = (m_dir == DIR_UP);
		s.drive_close = (m_dir == DIR_DOWN);
		s.position_now = m_pos;
		s.vent_mode = m_vent;
		s.save_strobe = m_strobe;
		return s;
	endfunction

	function automatic void check_field(string name, logic [9:0] expv, logic [9:0] act);
		if (act !== expv) begin
			$error("%s: expected %0d, actual %0d", name, expv, act);
			mismatches++;
		end
	endfunction

	function automatic logic [9:0] nearby(int c);
		int v;
		v = c + int'($urandom_range(0, 8)) - 4;
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		return 10'(v);
	endfunction

	task automatic queue_item(logic [2:0] op, logic rel, logic [9:0] rv);
		shutter_item_t it;
		it.op = op;
		it.rel = rel;
		it.rv = rv;
		pending_items.push_back(it);
		queued_count++;
	endtask

	// Mostly complete button strokes and ventilation runs, with noise in between.
	task automatic queue_random(int unsigned n);
		int unsigned start;
		int unsigned kind;
		int unsigned ticks;
		logic [2:0] btn;
		start = queued_count;
		while (queued_count - start < n) begin
			kind = $urandom_range(0, 9);
			if (kind <= 3) begin
				if ($urandom_range(0, 1))
					queue_item(OP_RESTORE, 1'($urandom), nearby($urandom_range(0, 1) ? 0 : m_travel));
				btn = $urandom_range(0, 1) ? OP_UP : OP_DOWN;
				queue_item(btn, 1'b0, 10'($urandom));
				ticks = $urandom_range(0, 8);
				repeat (ticks) begin
					if ($urandom_range(0, 9) == 0)
						queue_item($urandom_range(0, 1) ? OP_UP : OP_DOWN, 1'($urandom),
							10'($urandom));
					else
						queue_item(OP_TICK, 1'($urandom), 10'($urandom));
				end
				if ($urandom_range(0, 3) != 0)
					queue_item(btn, 1'b1, 10'($urandom));
			end else if (kind <= 5) begin
				if ($urandom_range(0, 1))
					queue_item(OP_RESTORE, 1'($urandom), nearby(m_vent_pos));
				queue_item(OP_VENT, 1'($urandom), 10'($urandom));
				ticks = $urandom_range(0, 8);
				repeat (ticks)
					queue_item(OP_TICK, 1'($urandom), 10'($urandom));
			end else if (kind == 6) begin
				queue_item(OP_RESTORE, 1'($urandom), 10'($urandom));
			end else begin
				queue_item(3'($urandom_range(0, 7)), 1'($urandom), 10'($urandom));
			end
		end
	endtask

	task automatic drain_results();
		while (accepted_count != queued_count || expected_status.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic apb_write(reg_idx_t idx, logic [9:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_BITS'(int'(idx) * 4);
		pwdata <= APB_DATA_BITS'(val);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// The last restore of a phase often leaves the position beyond the next full_travel.
	task automatic run_phase(logic [9:0] travel, logic [9:0] vent_pos, int unsigned n);
		queue_item(OP_RESTORE, 1'b0, 10'($urandom));
		drain_results();
		apb_write(REG_FULL_TRAVEL, travel);
		m_travel = travel;
		apb_write(REG_VENT_TARGET, vent_pos);
		m_vent_pos = vent_pos;
		queue_random(n);
	endtask

	// Sender: waits a drawn number of cycles before each transaction.
	always @(negedge clk) begin
		if (!arst_n) begin
			item_bus.valid <= 1'b0;
		end else if (!item_bus.valid || in_fire) begin
			if (send_wait > 0) begin
				send_wait--;
				item_bus.valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				next_item = pending_items.pop_front();
				item_bus.opcode <= next_item.op;
				item_bus.button_released <= next_item.rel;
				item_bus.restore_value <= next_item.rv;
				item_bus.valid <= 1'b1;
				if ($urandom_range(0, 31) == 0)
					send_steady = !send_steady;
				send_wait = send_steady ? 0 : $urandom_range(0, 4);
			end else begin
				item_bus.valid <= 1'b0;
			end
		end
	end

	// Receiver: stalls a drawn number of cycles after each transaction.
	always @(negedge clk) begin
		if (!arst_n) begin
			result_bus.ready <= 1'b0;
		end else begin
			if (out_fire) begin
				if ($urandom_range(0, 31) == 0)
					recv_steady = !recv_steady;
				recv_wait = recv_steady ? 0 : $urandom_range(0, 4);
			end
			if (recv_wait > 0) begin
				recv_wait--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			in_fire <= 1'b0;
			out_fire <= 1'b0;
			idle_cycles = 0;
		end else begin
			in_fire <= item_bus.valid && item_bus.ready;
			out_fire <= result_bus.valid && result_bus.ready;
			if (item_bus.valid && item_bus.ready) begin
				expected_status.push_back(advance_shutter(item_bus.opcode,
					item_bus.button_released, item_bus.restore_value));
				accepted_count++;
			end
			if (result_bus.valid && result_bus.ready) begin
				if (expected_status.size() == 0) begin
					$error("result transaction with no expected status pending");
					mismatches++;
				end else begin
					want = expected_status.pop_front();
					check_field("drive_open", 10'(want.drive_open), 10'(result_bus.drive_open));
					check_field("drive_close", 10'(want.drive_close),
						10'(result_bus.drive_close));
					check_field("position_now", want.position_now, result_bus.position_now);
					check_field("vent_mode", 10'(want.vent_mode), 10'(result_bus.vent_mode));
					check_field("save_strobe", 10'(want.save_strobe),
						10'(result_bus.save_strobe));
				end
			end
			if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		item_bus.valid = 1'b0;
		item_bus.opcode = OP_TICK;
		item_bus.button_released = 1'b1;
		item_bus.restore_value = '0;
		result_bus.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		m_travel = FULL_TRAVEL_RESET;
		m_vent_pos = VENT_TARGET_RESET;
		m_pos = '0;
		m_dir = DIR_IDLE;
		m_vent = 1'b0;
		m_lock = '0;
		m_strobe = 1'b0;
		queued_count = 0;
		accepted_count = 0;
		mismatches = 0;
		send_wait = 0;
		recv_wait = 0;
		send_steady = 1'b0;
		recv_steady = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: idle tick, refused starts, idle release, unused opcodes, saturation.
		queue_item(OP_TICK, 1'b1, 10'd0);
		queue_item(OP_UP, 1'b0, 10'd0);
		queue_item(OP_UP, 1'b1, 10'd0);
		queue_item(3'd5, 1'b0, 10'h3FF);
		queue_item(3'd7, 1'b1, 10'h2AA);
		queue_item(OP_RESTORE, 1'b0, 10'd1023);
		queue_item(OP_DOWN, 1'b0, 10'd0);
		queue_item(OP_DOWN, 1'b1, 10'd0);
		// Reversal, then a run into the closed end.
		queue_item(OP_RESTORE, 1'b1, 10'd998);
		queue_item(OP_UP, 1'b0, 10'd0);
		queue_item(OP_DOWN, 1'b0, 10'd0);
		queue_item(OP_TICK, 1'b0, 10'd0);
		queue_item(OP_TICK, 1'b0, 10'd0);
		queue_item(OP_DOWN, 1'b1, 10'd0);
		// Up press while the up lock from the reversal is still held: ignored, then the release unlocks.
		queue_item(OP_RESTORE, 1'b0, 10'd1);
		queue_item(OP_UP, 1'b0, 10'd0);
		queue_item(OP_TICK, 1'b0, 10'd0);
		queue_item(OP_UP, 1'b1, 10'd0);
		// Ventilation: already at target, then a run that stops on the target.
		queue_item(OP_RESTORE, 1'b0, 10'd500);
		queue_item(OP_VENT, 1'b0, 10'd0);
		queue_item(OP_RESTORE, 1'b0, 10'd498);
		queue_item(OP_VENT, 1'b1, 10'd0);
		queue_item(OP_VENT, 1'b0, 10'd0);
		queue_item(OP_DOWN, 1'b0, 10'd0);
		queue_item(OP_TICK, 1'b0, 10'd0);
		queue_item(OP_TICK, 1'b0, 10'd0);
		queue_item(OP_DOWN, 1'b1, 10'd0);

		queue_random(80);
		run_phase(10'd1, 10'd0, 90);
		run_phase(10'd1023, 10'd1023, 90);
		run_phase(10'd40, 10'd20, 90);
		run_phase(10'd1023, 10'd0, 90);
		run_phase(10'd12, 10'd600, 90);

		drain_results();
		repeat (3) @(negedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
